>>> hdl/sbpm_pkg.sv
// Shared types, constants and helpers for the sprite blitter.
package sbpm_pkg;

  // Field and storage widths
  localparam int unsigned DimW       = 11;
  localparam int unsigned CoordW     = 10;
  localparam int unsigned PixW       = 16;
  localparam int unsigned SlotW      = 8;
  localparam int unsigned PalDepth   = 256;
  localparam int unsigned PalIdxW    = $clog2(PalDepth);
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned MaxDim     = 1024;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // Item kinds on the input channel
  typedef enum logic {
    ActPalette = 1'b0,
    ActPixel   = 1'b1
  } action_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgDestWidth  = 4'd0,
    CfgDestHeight = 4'd1,
    CfgSrcWidth   = 4'd2,
    CfgSrcHeight  = 4'd3,
    CfgOffsetX    = 4'd4,
    CfgOffsetY    = 4'd5,
    CfgMirror     = 4'd6,
    CfgUsePalette = 4'd7
  } cfg_idx_e;

  // One queued command from front to back
  typedef struct packed {
    action_e              kind;     // palette write or visible pixel
    logic [PalIdxW-1:0]   addr;     // palette slot or palette index
    logic [PixW-1:0]      data;     // palette colour or raw pixel
    logic [CoordW-1:0]    x;
    logic [CoordW-1:0]    y;
    logic                 use_pal;
  } cmd_t;

  // Saturate a size register to 1..MaxDim
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> hdl/sprite_blit_palette_mirror.sv
// Top level of the sprite blitter: front end, command queue and back end.
// Takes one input word per clock while in_stall_o is low: a palette write or the
// next sprite pixel in row-major order. The front end keeps the sprite column and
// row, mirrors, offsets and clips, and drops transparent pixels; palette writes and
// visible pixels go through a four-entry queue to the back end, which owns the
// palette memory, so palette writes and lookups stay in input order. A visible
// pixel passes the front stage register, a queue slot, the lookup stage and the
// output register; throughput is one word per cycle when nothing stalls, bounded
// by the back end taking one queued command per cycle. Config writes are always
// ready and must be made only while the block is idle.
module sprite_blit_palette_mirror
  import sbpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [SlotW-1:0]   palette_slot_i,
  input  logic [PixW-1:0]    palette_colour_i,
  input  logic [PixW-1:0]    pixel_value_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CoordW-1:0]  write_x_o,
  output logic [CoordW-1:0]  write_y_o,
  output logic [PixW-1:0]    write_value_o
);

  logic push, pop, full, empty;
  cmd_t push_cmd, head_cmd;

  sbpm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .palette_slot_i   (palette_slot_i),
    .palette_colour_i (palette_colour_i),
    .pixel_value_i    (pixel_value_i),
    .push_o           (push),
    .cmd_o            (push_cmd),
    .full_i           (full)
  );

  sbpm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  sbpm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (head_cmd),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .write_x_o     (write_x_o),
    .write_y_o     (write_y_o),
    .write_value_o (write_value_o)
  );

  // queue never overflows or underflows
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("command pushed into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !empty)
    else $error("command popped from empty queue");
  // a stalled input means the front stage is blocked by a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> full)
    else $error("input stalled while queue has room");

endmodule

>>> hdl/sbpm_front.sv
// Front end: config registers, sprite counters, clipping and classification.
module sbpm_front
  import sbpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [SlotW-1:0]   palette_slot_i,
  input  logic [PixW-1:0]    palette_colour_i,
  input  logic [PixW-1:0]    pixel_value_i,
  // queue push side
  output logic               push_o,
  output cmd_t               cmd_o,
  input  logic               full_i
);

  // config registers
  logic [DimW-1:0] dest_w_q, dest_h_q, src_w_q, src_h_q;
  logic [DimW-1:0] off_x_q, off_y_q;
  logic            mirror_q, use_pal_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_w_q  <= DimW'(MaxDim);
      dest_h_q  <= DimW'(MaxDim);
      src_w_q   <= DimW'(1);
      src_h_q   <= DimW'(1);
      off_x_q   <= '0;
      off_y_q   <= '0;
      mirror_q  <= 1'b0;
      use_pal_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgDestWidth:  dest_w_q  <= cfg_data_i;
        CfgDestHeight: dest_h_q  <= cfg_data_i;
        CfgSrcWidth:   src_w_q   <= cfg_data_i;
        CfgSrcHeight:  src_h_q   <= cfg_data_i;
        CfgOffsetX:    off_x_q   <= cfg_data_i;
        CfgOffsetY:    off_y_q   <= cfg_data_i;
        CfgMirror:     mirror_q  <= cfg_data_i[0];
        CfgUsePalette: use_pal_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // saturated sizes
  logic [DimW-1:0] sw, sh, dw, dh;
  assign sw = clamp_dim(src_w_q);
  assign sh = clamp_dim(src_h_q);
  assign dw = clamp_dim(dest_w_q);
  assign dh = clamp_dim(dest_h_q);

  // stage registers and sprite counters
  logic                s1_valid_q, s1_valid_d;
  action_e             s1_kind_q;
  logic [SlotW-1:0]    s1_slot_q;
  logic [PixW-1:0]     s1_colour_q, s1_value_q;
  logic [CoordW-1:0]   s1_col_q, s1_row_q;
  logic [CoordW-1:0]   col_q, col_d, row_q, row_d;
  logic                accept, s1_go, s1_push;

  assign in_stall_o = s1_valid_q && !s1_go;
  assign accept     = in_valid_i && !in_stall_o;

  // counter advance on every accepted pixel
  logic [DimW-1:0] col_inc, row_inc;
  always_comb begin
    col_inc = {1'b0, col_q} + DimW'(1);
    row_inc = {1'b0, row_q} + DimW'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (accept && action_e'(action_i) == ActPixel) begin
      if (col_inc >= sw) begin
        col_d = '0;
        row_d = (row_inc >= sh) ? '0 : row_inc[CoordW-1:0];
      end else begin
        col_d = col_inc[CoordW-1:0];
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      col_q      <= col_d;
      row_q      <= row_d;
    end
  end

  // payload of the stage, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q   <= action_e'(action_i);
      s1_slot_q   <= palette_slot_i;
      s1_colour_q <= palette_colour_i;
      s1_value_q  <= pixel_value_i;
      s1_col_q    <= col_q;
      s1_row_q    <= row_q;
    end
  end

  // destination position and clipping
  logic signed [DimW+1:0] sx, dx, dy;
  logic                   clip, inside_x, inside_y, visible;
  always_comb begin
    clip = ({1'b0, s1_col_q} >= sw) || ({1'b0, s1_row_q} >= sh) || (s1_value_q == '0);
    if (mirror_q) begin
      sx = $signed({2'b00, sw}) - $signed((DimW+2)'(1)) - $signed({3'b000, s1_col_q});
    end else begin
      sx = $signed({3'b000, s1_col_q});
    end
    dx = sx + $signed({{2{off_x_q[DimW-1]}}, off_x_q});
    dy = $signed({3'b000, s1_row_q}) + $signed({{2{off_y_q[DimW-1]}}, off_y_q});
    inside_x = !dx[DimW+1] && (dx[DimW:0] < {1'b0, dw});
    inside_y = !dy[DimW+1] && (dy[DimW:0] < {1'b0, dh});
    visible  = !clip && inside_x && inside_y;
  end

  // hand the command to the queue
  assign s1_push = (s1_kind_q == ActPalette) || visible;
  assign s1_go   = s1_valid_q && (!s1_push || !full_i);
  assign push_o  = s1_valid_q && s1_push && !full_i;

  always_comb begin
    cmd_o.kind    = s1_kind_q;
    cmd_o.addr    = (s1_kind_q == ActPalette) ? s1_slot_q[PalIdxW-1:0]
                                              : s1_value_q[PalIdxW-1:0];
    cmd_o.data    = (s1_kind_q == ActPalette) ? s1_colour_q : s1_value_q;
    cmd_o.x       = dx[CoordW-1:0];
    cmd_o.y       = dy[CoordW-1:0];
    cmd_o.use_pal = use_pal_q;
  end

endmodule

>>> hdl/sbpm_fifo.sv
// Short command queue between front and back.
module sbpm_fifo
  import sbpm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  input  logic pop_i,
  output cmd_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t                 slots_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = slots_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QueuePtrW'(1);
      if (pop_i)  rd_q <= rd_q + QueuePtrW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (QueuePtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QueuePtrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_q] <= wdata_i;
  end

endmodule

>>> hdl/sbpm_back.sv
// Back end: palette memory, lookup stage and output register.
module sbpm_back
  import sbpm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // queue pop side
  input  cmd_t              cmd_i,
  input  logic              empty_i,
  output logic              pop_o,
  // result words
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CoordW-1:0] write_x_o,
  output logic [CoordW-1:0] write_y_o,
  output logic [PixW-1:0]   write_value_o
);

  logic [PixW-1:0] pal_mem [PalDepth];

  // lookup stage
  logic              b1_valid_q, b1_valid_d;
  logic [CoordW-1:0] b1_x_q, b1_y_q;
  logic [PixW-1:0]   b1_raw_q, b1_rd_q;
  logic              b1_use_pal_q;
  logic              out_valid_q;
  logic              b1_adv, b1_free, load_b1, pal_wr;

  assign b1_adv  = b1_valid_q && (!out_valid_q || !out_stall_i);
  assign b1_free = !b1_valid_q || b1_adv;
  assign pop_o   = !empty_i && ((cmd_i.kind == ActPalette) || b1_free);
  assign pal_wr  = pop_o && (cmd_i.kind == ActPalette);
  assign load_b1 = pop_o && (cmd_i.kind == ActPixel);

  always_comb begin
    b1_valid_d = b1_valid_q;
    if (load_b1) begin
      b1_valid_d = 1'b1;
    end else if (b1_adv) begin
      b1_valid_d = 1'b0;
    end
  end

  // palette memory: write on palette command, registered read on pixel
  always_ff @(posedge clk_i) begin
    if (pal_wr) pal_mem[cmd_i.addr] <= cmd_i.data;
    if (load_b1) b1_rd_q <= pal_mem[cmd_i.addr];
  end

  always_ff @(posedge clk_i) begin
    if (load_b1) begin
      b1_x_q       <= cmd_i.x;
      b1_y_q       <= cmd_i.y;
      b1_raw_q     <= cmd_i.data;
      b1_use_pal_q <= cmd_i.use_pal;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b1_valid_q <= b1_valid_d;
      if (b1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_adv) begin
      write_x_o     <= b1_x_q;
      write_y_o     <= b1_y_q;
      write_value_o <= b1_use_pal_q ? b1_rd_q : b1_raw_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
